// ===== rtl/vrmu_pkg.sv =====
package vrmu_pkg;

  typedef enum logic [3:0] {
    CMD_ZERO      = 4'd0,
    CMD_PLOAD     = 4'd1,
    CMD_PSTORE    = 4'd2,
    CMD_SLOAD     = 4'd3,
    CMD_SSTORE    = 4'd4,
    CMD_TO_VEC    = 4'd5,
    CMD_FROM_VEC  = 4'd6,
    CMD_QSTORE    = 4'd7,
    CMD_MERGE_LO  = 4'd8,
    CMD_MERGE_HI  = 4'd9,
    CMD_STORE_LQ  = 4'd10,
    CMD_STORE_HQ  = 4'd11,
    CMD_QLOAD     = 4'd12,
    CMD_QDUP      = 4'd13,
    CMD_EXTRACT   = 4'd14,
    CMD_UNKNOWN   = 4'd15
  } cmd_t;

  localparam logic [5:0] BYTES_NONE = 6'd0;
  localparam logic [5:0] BYTES_4    = 6'd4;
  localparam logic [5:0] BYTES_8    = 6'd8;
  localparam logic [5:0] BYTES_16   = 6'd16;
  localparam logic [5:0] BYTES_32   = 6'd32;

  localparam logic [63:0] MASK_DWORD = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] MASK_QWORD = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

// ===== rtl/vector_register_move_unit.sv =====
// Vector register move unit: a file of 256-bit vector registers, each held as
// four quadwords, and an execution path for decoded move commands.
// Input channel (in_valid/in_ready): one command beat with register numbers,
// form flags, lane select and up to four load quadwords.
// Output channel (out_valid/out_ready): one result beat per command with the
// store data, store length and general-register write value.
// A command is taken into an input register, executed through one level of
// register-file reads and selection, and lands in the result register while
// the register file is updated. The result is then offered from the result
// register, and one command can be taken every cycle while the receiver
// does not stall.
// Commands update the register file strictly in the order they are taken.
// Reset empties both stages and clears every vector register to zero.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more command; after that in_ready falls until the
// result is taken. No beat is dropped or repeated.
module vector_register_move_unit #(
  parameter int NUM_VECTOR_REGS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  command,
  input  logic        vector_long,
  input  logic        wide,
  input  logic        register_form,
  input  logic [3:0]  reg_field,
  input  logic [3:0]  rm_field,
  input  logic [3:0]  second_source,
  input  logic [1:0]  lane_select,
  input  logic [63:0] load_q0,
  input  logic [63:0] load_q1,
  input  logic [63:0] load_q2,
  input  logic [63:0] load_q3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        handled,
  output logic        mem_write,
  output logic [5:0]  store_bytes,
  output logic [63:0] store_q0,
  output logic [63:0] store_q1,
  output logic [63:0] store_q2,
  output logic [63:0] store_q3,
  output logic        gpr_write,
  output logic [63:0] gpr_value
);
  import vrmu_pkg::*;

  localparam int IW = $clog2(NUM_VECTOR_REGS);
  localparam logic [4:0] NREG5 = 5'(NUM_VECTOR_REGS);

  function automatic logic [IW-1:0] wrap_idx(input logic [3:0] f);
    logic [4:0] f5;
    f5 = {1'b0, f};
    if (f5 >= NREG5) begin
      f5 = f5 - NREG5;
    end
    return f5[IW-1:0];
  endfunction

  // Register file: two low-half and two high-half quadwords per register.
  logic [63:0] lo0 [NUM_VECTOR_REGS];
  logic [63:0] lo1 [NUM_VECTOR_REGS];
  logic [63:0] hi0 [NUM_VECTOR_REGS];
  logic [63:0] hi1 [NUM_VECTOR_REGS];

  // Input register
  logic        s1_valid;
  cmd_t        s1_cmd;
  logic        s1_long, s1_wide, s1_regf;
  logic [IW-1:0] s1_d, s1_s, s1_v;
  logic [1:0]  s1_lane;
  logic [63:0] s1_m0, s1_m1, s1_m2, s1_m3;

  logic s1_adv;
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_cmd  <= cmd_t'(command);
      s1_long <= vector_long;
      s1_wide <= wide;
      s1_regf <= register_form;
      s1_d    <= wrap_idx(reg_field);
      s1_s    <= wrap_idx(rm_field);
      s1_v    <= wrap_idx(second_source);
      s1_lane <= lane_select;
      s1_m0   <= load_q0;
      s1_m1   <= load_q1;
      s1_m2   <= load_q2;
      s1_m3   <= load_q3;
    end
  end

  // Execute
  logic [63:0] em;
  logic        wr_en, clr_hi_all, clr_lo_all;
  logic [IW-1:0] wr_idx;
  logic [63:0] wa, wb, wc, we;
  logic        handled_next, mw_next, gw_next;
  logic [5:0]  nb_next;
  logic [63:0] sq0_next, sq1_next, sq2_next, sq3_next, gv_next;
  logic [63:0] ext;

  assign em = s1_wide ? MASK_QWORD : MASK_DWORD;

  always_comb begin
    wr_en = 1'b0; clr_hi_all = 1'b0; clr_lo_all = 1'b0;
    wr_idx = s1_d;
    wa = '0; wb = '0; wc = '0; we = '0;
    handled_next = 1'b1; mw_next = 1'b0; gw_next = 1'b0;
    nb_next = BYTES_NONE;
    sq0_next = '0; sq1_next = '0; sq2_next = '0; sq3_next = '0; gv_next = '0;
    ext = s1_lane[1] ? lo1[s1_d] : lo0[s1_d];
    case (s1_cmd)
      CMD_ZERO: begin
        clr_hi_all = 1'b1;
        clr_lo_all = s1_long;
      end
      CMD_PLOAD: begin
        wr_en = 1'b1;
        if (s1_regf) begin
          wa = lo0[s1_s]; wb = lo1[s1_s];
          wc = s1_long ? hi0[s1_s] : '0; we = s1_long ? hi1[s1_s] : '0;
        end else begin
          wa = s1_m0; wb = s1_m1;
          wc = s1_long ? s1_m2 : '0; we = s1_long ? s1_m3 : '0;
        end
      end
      CMD_PSTORE: begin
        wa = lo0[s1_d]; wb = lo1[s1_d];
        wc = s1_long ? hi0[s1_d] : '0; we = s1_long ? hi1[s1_d] : '0;
        if (s1_regf) begin
          wr_en = 1'b1; wr_idx = s1_s;
        end else begin
          mw_next = 1'b1;
          nb_next = s1_long ? BYTES_32 : BYTES_16;
          sq0_next = wa; sq1_next = wb; sq2_next = wc; sq3_next = we;
        end
      end
      CMD_SLOAD: begin
        wr_en = 1'b1;
        if (s1_regf) begin
          wa = (lo0[s1_v] & ~em) | (lo0[s1_s] & em);
          wb = lo1[s1_v];
        end else begin
          wa = s1_m0 & em;
        end
      end
      CMD_SSTORE: begin
        if (s1_regf) begin
          wr_en = 1'b1; wr_idx = s1_s;
          wa = (lo0[s1_v] & ~em) | (lo0[s1_d] & em);
          wb = lo1[s1_v];
        end else begin
          mw_next = 1'b1;
          nb_next = s1_wide ? BYTES_8 : BYTES_4;
          sq0_next = lo0[s1_d] & em;
        end
      end
      CMD_TO_VEC: begin
        wr_en = 1'b1;
        wa = s1_m0 & em;
      end
      CMD_FROM_VEC: begin
        if (s1_regf) begin
          gw_next = 1'b1; gv_next = lo0[s1_d] & em;
        end else begin
          mw_next = 1'b1;
          nb_next = s1_wide ? BYTES_8 : BYTES_4;
          sq0_next = lo0[s1_d] & em;
        end
      end
      CMD_QSTORE: begin
        if (s1_regf) begin
          wr_en = 1'b1; wr_idx = s1_s; wa = lo0[s1_d];
        end else begin
          mw_next = 1'b1; nb_next = BYTES_8; sq0_next = lo0[s1_d];
        end
      end
      CMD_MERGE_LO: begin
        wr_en = 1'b1;
        wa = s1_regf ? lo1[s1_s] : s1_m0;
        wb = lo1[s1_v];
      end
      CMD_MERGE_HI: begin
        wr_en = 1'b1;
        wa = lo0[s1_v];
        wb = s1_regf ? lo0[s1_s] : s1_m0;
      end
      CMD_STORE_LQ: begin
        if (!s1_regf) begin
          mw_next = 1'b1; nb_next = BYTES_8; sq0_next = lo0[s1_d];
        end
      end
      CMD_STORE_HQ: begin
        if (!s1_regf) begin
          mw_next = 1'b1; nb_next = BYTES_8; sq0_next = lo1[s1_d];
        end
      end
      CMD_QLOAD: begin
        wr_en = 1'b1;
        wa = s1_regf ? lo0[s1_s] : s1_m0;
      end
      CMD_QDUP: begin
        wr_en = 1'b1;
        wa = s1_regf ? lo0[s1_s] : s1_m0;
        wb = wa;
        wc = s1_long ? (s1_regf ? hi0[s1_s] : s1_m2) : '0;
        we = wc;
      end
      CMD_EXTRACT: begin
        // The odd lanes sit in the upper doubleword of their quadword.
        if (s1_lane[0]) begin
          ext = {32'd0, ext[63:32]};
        end else begin
          ext = ext & MASK_DWORD;
        end
        if (s1_regf) begin
          gw_next = 1'b1; gv_next = ext;
        end else begin
          mw_next = 1'b1; nb_next = BYTES_4; sq0_next = ext;
        end
      end
      default: begin
        handled_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VECTOR_REGS; i++) begin
        lo0[i] <= '0; lo1[i] <= '0; hi0[i] <= '0; hi1[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < NUM_VECTOR_REGS; i++) begin
        if (clr_hi_all) begin
          hi0[i] <= '0; hi1[i] <= '0;
        end
        if (clr_lo_all) begin
          lo0[i] <= '0; lo1[i] <= '0;
        end
      end
      if (wr_en) begin
        lo0[wr_idx] <= wa; lo1[wr_idx] <= wb;
        hi0[wr_idx] <= wc; hi1[wr_idx] <= we;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv) begin
      handled     <= handled_next;
      mem_write   <= mw_next;
      store_bytes <= nb_next;
      store_q0    <= sq0_next;
      store_q1    <= sq1_next;
      store_q2    <= sq2_next;
      store_q3    <= sq3_next;
      gpr_write   <= gw_next;
      gpr_value   <= gv_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_double_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(mem_write && gpr_write))
    else $error("result writes both memory and a general register");

  a_len_matches_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mem_write |-> store_bytes == BYTES_NONE && store_q0 == '0)
    else $error("store length or data present without a memory write");

  a_unknown_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !handled |-> !mem_write && !gpr_write)
    else $error("unknown command produced a write");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while both stages are full and stalled");
`endif

endmodule
